### rtl/core/ogl_pkg.sv
// shared types and constants for the occupancy grid line-of-sight block
// no dependencies; imported by ogl_row_mem, occupancy_grid_line_of_sight_top and the testbench
`timescale 1ns / 1ps

package ogl_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int CFG_W   = 9;
  localparam int COORD_W = 16;
  localparam int CMP_W   = COORD_W + 1;
  localparam int DIST_W  = COORD_W + 1;
  localparam int ERR_W   = DIST_W + 2;

  localparam int IN_DATA_W  = 4 * COORD_W;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    ACT_MARK = 1'b0,
    ACT_LOS  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MARK,
    S_LOS,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 re;
    logic [ROW_W-1:0]     raddr;
    logic                 we;
    logic [ROW_W-1:0]     waddr;
    logic [MAX_WIDTH-1:0] wdata;
  } row_req_t;

endpackage

### rtl/core/ogl_row_mem.sv
// occupancy storage: one row of cells per word, one read and one write port
// rows never written read as all walkable through per-row valid flags; uses ogl_pkg
`timescale 1ns / 1ps

module ogl_row_mem (
  input  logic                          clk,
  input  logic                          rst,
  input  ogl_pkg::row_req_t             req,
  output logic [ogl_pkg::MAX_WIDTH-1:0] rdata
);
  import ogl_pkg::*;

  logic [MAX_WIDTH-1:0]  mem [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0] row_valid;
  logic [MAX_WIDTH-1:0]  rdata_q;
  logic                  rvalid_q;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_q <= mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      if (req.we) begin
        row_valid[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        rvalid_q <= row_valid[req.raddr];
      end
    end
  end

  // a row that was never written is all walkable
  assign rdata = rdata_q & {MAX_WIDTH{rvalid_q}};

endmodule

### rtl/core/occupancy_grid_line_of_sight_top.sv
// occupancy grid with rectangle marking and bresenham line-of-sight queries
// depends on ogl_pkg and ogl_row_mem
//
//   channel   dir   handshake            payload
//   s_*       in    s_tvalid / s_tready  tuser: action; tdata: x_a, z_a, x_b, z_b
//   m_*       out   m_tvalid / m_tready  tuser: done_action; tdata: clear
//   cfg_*     in    cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// a mark reads and writes back one clamped row per cycle (read and write-back overlap);
// an empty rectangle reads and writes no row
// a query visits one cell per cycle, each checked against the registered row read
// one item is worked at a time; the next is taken while the last result waits in m_*
// reset clears per-row valid flags at once, so no clearing pass is needed
`timescale 1ns / 1ps

module occupancy_grid_line_of_sight_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ogl_pkg::IN_DATA_W-1:0]      s_tdata,   // x_a, z_a, x_b, z_b
  input  logic                               s_tuser,   // action
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ogl_pkg::OUT_DATA_W-1:0]     m_tdata,   // clear, zero pad
  output logic                               m_tuser,   // done_action
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [0:0]                         cfg_index,
  input  logic [ogl_pkg::CFG_W-1:0]          cfg_data
);
  import ogl_pkg::*;

  state_t state, state_next;

  logic [CFG_W-1:0] grid_width, grid_height;
  logic signed [CMP_W-1:0] used_w, used_h;

  // input fields
  logic signed [COORD_W-1:0] x_a, z_a, x_b, z_b;
  logic signed [CMP_W-1:0]   xa_e, za_e, xb_e, zb_e;
  logic in_acc;

  // mark context
  logic [COL_W-1:0] mx0, mx1;
  logic [ROW_W-1:0] mz, mz1, mk_row;
  logic             mk_more, mk_pend;
  logic signed [CMP_W-1:0] cx0, cx1, cz0, cz1;
  logic             rect_empty;
  logic [MAX_WIDTH-1:0] mask;

  // line context
  logic signed [COORD_W-1:0] px, pz, ex, ez;
  logic [DIST_W-1:0]         dx, dz;
  logic                      sx_neg, sz_neg;
  logic signed [ERR_W-1:0]   err, err_next;
  logic signed [ERR_W:0]     e2, dx_w, dz_w;
  logic                      step_x, step_z;
  logic                      ls_more, ls_inside, ls_last;
  logic signed [CMP_W-1:0]   px_e, pz_e, dx_diff, dz_diff;
  logic [DIST_W-1:0]         dx_a, dz_a;
  logic                      ck_valid, ck_in, ck_last;
  logic [COL_W-1:0]          ck_x;
  logic                      blocked, los_end;

  // result
  logic res_action, res_clear;
  logic out_valid, out_action, out_clear;
  logic out_load;

  row_req_t             req;
  logic [MAX_WIDTH-1:0] rd_row;

  ogl_row_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (rd_row)
  );

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= CFG_W'(256);
      grid_height <= CFG_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign used_w = (CMP_W'(grid_width) > CMP_W'(MAX_WIDTH)) ?
                  CMP_W'(MAX_WIDTH) : CMP_W'(grid_width);
  assign used_h = (CMP_W'(grid_height) > CMP_W'(MAX_HEIGHT)) ?
                  CMP_W'(MAX_HEIGHT) : CMP_W'(grid_height);

  // ---------------------------------------------------------------- input decode
  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;

  assign x_a = s_tdata[COORD_W-1:0];
  assign z_a = s_tdata[2*COORD_W-1:COORD_W];
  assign x_b = s_tdata[3*COORD_W-1:2*COORD_W];
  assign z_b = s_tdata[4*COORD_W-1:3*COORD_W];

  assign xa_e = {x_a[COORD_W-1], x_a};
  assign za_e = {z_a[COORD_W-1], z_a};
  assign xb_e = {x_b[COORD_W-1], x_b};
  assign zb_e = {z_b[COORD_W-1], z_b};

  // rectangle clamped to the grid in use
  assign cx0 = (xa_e < 0) ? '0 : xa_e;
  assign cz0 = (za_e < 0) ? '0 : za_e;
  assign cx1 = (xb_e > used_w - CMP_W'(1)) ? used_w - CMP_W'(1) : xb_e;
  assign cz1 = (zb_e > used_h - CMP_W'(1)) ? used_h - CMP_W'(1) : zb_e;
  assign rect_empty = (cx0 > cx1) || (cz0 > cz1);

  // line setup
  assign dx_diff = xb_e - xa_e;
  assign dz_diff = zb_e - za_e;
  assign dx_a    = DIST_W'((dx_diff < 0) ? -dx_diff : dx_diff);
  assign dz_a    = DIST_W'((dz_diff < 0) ? -dz_diff : dz_diff);

  // ---------------------------------------------------------------- bresenham step
  assign e2     = {err, 1'b0};
  assign dx_w   = $signed({3'b000, dx});
  assign dz_w   = $signed({3'b000, dz});
  assign step_x = e2 > -dz_w;
  assign step_z = e2 < dx_w;

  always_comb begin
    err_next = err;
    if (step_x) begin
      err_next = err_next - $signed({2'b00, dz});
    end
    if (step_z) begin
      err_next = err_next + $signed({2'b00, dx});
    end
  end

  assign px_e      = {px[COORD_W-1], px};
  assign pz_e      = {pz[COORD_W-1], pz};
  assign ls_inside = (px_e >= 0) && (pz_e >= 0) && (px_e < used_w) && (pz_e < used_h);
  assign ls_last   = (px == ex) && (pz == ez);

  // check stage: row data for the cell issued last cycle
  assign blocked = !ck_in || rd_row[ck_x];
  assign los_end = ck_valid && (blocked || ck_last);

  // ---------------------------------------------------------------- memory access
  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      mask[i] = (COL_W'(i) >= mx0) && (COL_W'(i) <= mx1);
    end
  end

  always_comb begin
    req.re    = 1'b0;
    req.raddr = mz;
    req.we    = (state == S_MARK) && mk_pend;
    req.waddr = mk_row;
    req.wdata = rd_row | mask;
    case (state)
      S_MARK: req.re = mk_more;
      S_LOS: begin
        req.re    = ls_more && ls_inside;
        req.raddr = pz[ROW_W-1:0];
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- control
  assign out_load = (state == S_DONE) && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = (s_tuser == ACT_LOS) ? S_LOS : S_MARK;
        end
      end
      S_MARK: begin
        if (!mk_more && !mk_pend) begin
          state_next = S_DONE;
        end
      end
      S_LOS: begin
        if (los_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      mk_more  <= 1'b0;
      mk_pend  <= 1'b0;
      ls_more  <= 1'b0;
      ck_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            mk_more  <= (s_tuser == ACT_MARK) && !rect_empty;
            mk_pend  <= 1'b0;
            ls_more  <= (s_tuser == ACT_LOS);
            ck_valid <= 1'b0;
          end
        end
        S_MARK: begin
          mk_pend <= mk_more;
          if (mk_more) begin
            mk_more <= (mz != mz1);
          end
        end
        S_LOS: begin
          ck_valid <= ls_more;
          if (ls_more) begin
            ls_more <= ls_inside && !ls_last;
          end
        end
        default: ;
      endcase
    end
  end

  // payload of the item in work
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          res_action <= s_tuser;
          res_clear  <= 1'b0;
          mx0 <= cx0[COL_W-1:0];
          mx1 <= cx1[COL_W-1:0];
          mz  <= cz0[ROW_W-1:0];
          mz1 <= cz1[ROW_W-1:0];
          px  <= x_a;
          pz  <= z_a;
          ex  <= x_b;
          ez  <= z_b;
          dx  <= dx_a;
          dz  <= dz_a;
          sx_neg <= !(x_a < x_b);
          sz_neg <= !(z_a < z_b);
          err <= $signed({2'b00, dx_a}) - $signed({2'b00, dz_a});
        end
      end
      S_MARK: begin
        mk_row <= mz;
        if (mk_more && (mz != mz1)) begin
          mz <= mz + ROW_W'(1);
        end
      end
      S_LOS: begin
        if (ls_more) begin
          ck_in   <= ls_inside;
          ck_last <= ls_last;
          ck_x    <= px[COL_W-1:0];
          err     <= err_next;
          if (step_x) begin
            px <= sx_neg ? px - COORD_W'(1) : px + COORD_W'(1);
          end
          if (step_z) begin
            pz <= sz_neg ? pz - COORD_W'(1) : pz + COORD_W'(1);
          end
        end
        if (los_end) begin
          res_clear <= !blocked;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_action <= res_action;
      out_clear  <= res_clear;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_action;
  assign m_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_clear};

endmodule

### tb/tb_occupancy_grid_line_of_sight_top.sv
// self-checking testbench for occupancy_grid_line_of_sight_top: grid marking and line-of-sight
// depends on ogl_pkg and the rtl of the block; holds its own occupancy grid to predict results
`timescale 1ns / 1ps

module tb_occupancy_grid_line_of_sight_top;
  import ogl_pkg::*;

  localparam int CELLS        = MAX_WIDTH * MAX_HEIGHT;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 108;

  typedef struct {
    action_t act;
    shortint xa;
    shortint za;
    shortint xb;
    shortint zb;
  } request_t;

  typedef struct {
    action_t act;
    bit      clear;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [0:0]            cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  // shadow of the block: grid contents and size registers
  bit                    grid_occupied [0:CELLS-1];
  logic [CFG_W-1:0]      cfg_width;
  logic [CFG_W-1:0]      cfg_height;

  outcome_t              expected_results [$];
  int                    errors = 0;
  int                    cycles = 0;
  bit                    idle_on = 1'b1;
  int                    rx_hold = 0;

  occupancy_grid_line_of_sight_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_occupancy_grid_line_of_sight_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int used_width();
    int w;
    w = cfg_width;
    return (w > MAX_WIDTH) ? MAX_WIDTH : w;
  endfunction

  function automatic int used_height();
    int h;
    h = cfg_height;
    return (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
  endfunction

  function automatic bit in_grid(int x, int z);
    return x >= 0 && z >= 0 && x < used_width() && z < used_height();
  endfunction

  function automatic void block_rect(int xl, int zl, int xh, int zh);
    int x0, z0, x1, z1;
    x0 = (xl < 0) ? 0 : xl;
    z0 = (zl < 0) ? 0 : zl;
    x1 = (xh > used_width() - 1) ? used_width() - 1 : xh;
    z1 = (zh > used_height() - 1) ? used_height() - 1 : zh;
    for (int z = z0; z <= z1; z++)
      for (int x = x0; x <= x1; x++)
        grid_occupied[x + z * MAX_WIDTH] = 1'b1;
  endfunction

  // bresenham walk, both ends visited, stops at the first out-of-grid or blocked cell
  function automatic bit sight_is_clear(int x0, int z0, int x1, int z1);
    int dx, dz, sx, sz, err, e2;
    bit ok, walking;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dz = (z1 > z0) ? z1 - z0 : z0 - z1;
    sx = (x0 < x1) ? 1 : -1;
    sz = (z0 < z1) ? 1 : -1;
    err = dx - dz;
    ok = 1'b1;
    walking = 1'b1;
    while (walking) begin
      if (!in_grid(x0, z0)) begin
        ok = 1'b0;
        walking = 1'b0;
      end else if (grid_occupied[x0 + z0 * MAX_WIDTH]) begin
        ok = 1'b0;
        walking = 1'b0;
      end else if (x0 == x1 && z0 == z1) begin
        walking = 1'b0;
      end else begin
        e2 = 2 * err;
        if (e2 > -dz) begin
          err -= dz;
          x0 += sx;
        end
        if (e2 < dx) begin
          err += dx;
          z0 += sz;
        end
      end
    end
    return ok;
  endfunction

  function automatic outcome_t predict_outcome(request_t r);
    outcome_t o;
    o.act = r.act;
    o.clear = 1'b0;
    if (r.act == ACT_MARK)
      block_rect(r.xa, r.za, r.xb, r.zb);
    else
      o.clear = sight_is_clear(r.xa, r.za, r.xb, r.zb);
    return o;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic request_t make_req(action_t act, int xa, int za, int xb, int zb);
    request_t r;
    r.act = act;
    r.xa = shortint'(xa);
    r.za = shortint'(za);
    r.xb = shortint'(xb);
    r.zb = shortint'(zb);
    return r;
  endfunction

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // mostly in and just around the grid, sometimes anywhere in the 16-bit range
  function automatic int pick_coord(int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return int'($urandom_range(0, span + 1)) - 1;
    if (r < 92) return span + int'($urandom_range(0, 3)) - 2;
    return int'(shortint'($urandom));
  endfunction

  function automatic request_t random_request();
    request_t r;
    int w, h, area, xa, za, xb, zb, side;
    w = used_width();
    h = used_height();
    area = w * h;
    side = (area >= 4096) ? 3 : 1;
    xa = pick_coord(w);
    za = pick_coord(h);
    if ($urandom_range(0, 99) < ((area >= 4096) ? 20 : 6)) begin
      // keep rectangles small so the grid does not fill up; some are reversed
      if ($urandom_range(0, 9) == 0) begin
        xb = xa - 1 - int'($urandom_range(0, 2));
        zb = za + int'($urandom_range(0, side));
      end else begin
        xb = xa + int'($urandom_range(0, side));
        zb = za + int'($urandom_range(0, side));
      end
      r = make_req(ACT_MARK, xa, za, sat16(xb), sat16(zb));
    end else begin
      if ($urandom_range(0, 9) < 3) begin
        xb = sat16(xa + int'($urandom_range(0, 8)) - 4);
        zb = sat16(za + int'($urandom_range(0, 8)) - 4);
      end else if ($urandom_range(0, 9) == 0) begin
        xb = xa;
        zb = za;
      end else begin
        xb = pick_coord(w);
        zb = pick_coord(h);
      end
      r = make_req(ACT_LOS, xa, za, xb, zb);
    end
    return r;
  endfunction

  task automatic send_item(input request_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.act;
    s_tdata  <= {r.zb, r.xb, r.za, r.xa};
    do @(posedge clk); while (!s_tready);
    expected_results.insert(expected_results.size(), predict_outcome(r));
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_GRID_WIDTH) cfg_width = value;
    else cfg_height = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_config(input int w, input int h);
    wait_results_drained();
    write_reg(REG_GRID_WIDTH, CFG_W'(w));
    write_reg(REG_GRID_HEIGHT, CFG_W'(h));
  endtask

  // ---------------------------------------------------------------- result side

  initial begin
    int stall;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
      end
      stall = idle_on ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: done_action=%0d clear=%0d",
               m_tuser, m_tdata[0]);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (m_tuser !== want.act) begin
          $error("done_action: expected %0d, got %0d", want.act, m_tuser);
          errors++;
        end
        if (m_tdata[0] !== want.clear) begin
          $error("clear: expected %0d, got %0d", want.clear, m_tdata[0]);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_clean_grid();
    send_item(make_req(ACT_LOS, 0, 0, 0, 0));
    send_item(make_req(ACT_LOS, 255, 255, 255, 255));
    send_item(make_req(ACT_LOS, 0, 0, 255, 255));
    send_item(make_req(ACT_LOS, 0, 255, 255, 0));
    send_item(make_req(ACT_LOS, 3, 200, 250, 210));
    send_item(make_req(ACT_LOS, 256, 0, 256, 0));
    send_item(make_req(ACT_LOS, 10, 10, -1, 5));
  endtask

  task automatic test_mark_clamp();
    send_item(make_req(ACT_MARK, -100, 250, 3, 250));
    send_item(make_req(ACT_MARK, 250, 240, 30000, 241));
    send_item(make_req(ACT_MARK, 210, 210, 209, 215));
    send_item(make_req(ACT_MARK, 300, 10, 400, 12));
    send_item(make_req(ACT_MARK, 200, 200, 200, 200));
    send_item(make_req(ACT_LOS, 0, 250, 10, 250));
    send_item(make_req(ACT_LOS, 5, 250, 10, 250));
    send_item(make_req(ACT_LOS, 205, 210, 215, 210));
    send_item(make_req(ACT_LOS, 195, 195, 205, 205));
    send_item(make_req(ACT_LOS, 190, 200, 200, 200));
    send_item(make_req(ACT_LOS, 255, 230, 255, 245));
  endtask

  task automatic test_size_change();
    write_config(16, 16);
    send_item(make_req(ACT_MARK, 10, 3, 10, 3));
    send_item(make_req(ACT_LOS, 10, 3, 10, 3));
    send_item(make_req(ACT_LOS, 9, 3, 9, 3));
    write_config(8, 16);
    send_item(make_req(ACT_LOS, 10, 3, 10, 3));
    send_item(make_req(ACT_LOS, 0, 3, 7, 3));
    send_item(make_req(ACT_LOS, 5, 5, 20, 5));
    write_config(256, 256);
    send_item(make_req(ACT_LOS, 10, 3, 10, 3));
    send_item(make_req(ACT_LOS, 0, 3, 9, 3));
  endtask

  // receiver stops for a long stretch while the sender keeps offering beats
  task automatic test_back_pressure();
    idle_on = 1'b0;
    rx_hold = 400;
    for (int i = 0; i < 16; i++)
      send_item(make_req(ACT_LOS, 40 + i, 60, 40 + i, 60 + (i % 3)));
    wait_results_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_random_phases();
    int sizes [0:8][0:1];
    int w, h;
    sizes = '{'{256, 256}, '{16, 16}, '{1, 256}, '{256, 1}, '{511, 300},
              '{37, 200}, '{2, 2}, '{0, 40}, '{100, 0}};
    for (int p = 0; p < PHASES; p++) begin
      if (p < 9) begin
        w = sizes[p][0];
        h = sizes[p][1];
      end else begin
        w = $urandom_range(0, 511);
        h = $urandom_range(0, 511);
      end
      write_config(w, h);
      idle_on = (p % 4 != 3);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_item(random_request());
    end
    idle_on = 1'b1;
  endtask

  task automatic test_register_extremes();
    write_config(0, 256);
    send_item(make_req(ACT_MARK, 0, 0, 5, 5));
    send_item(make_req(ACT_LOS, 0, 0, 0, 0));
    write_config(511, 511);
    send_item(make_req(ACT_LOS, 255, 255, 255, 255));
    send_item(make_req(ACT_LOS, 255, 100, 256, 100));
    send_item(make_req(ACT_MARK, 250, 120, 300, 120));
    send_item(make_req(ACT_LOS, 240, 120, 255, 120));
    write_config(1, 1);
    send_item(make_req(ACT_LOS, 0, 0, 0, 0));
    send_item(make_req(ACT_LOS, -32768, -32768, 32767, 32767));
    send_item(make_req(ACT_LOS, 0, 0, 32767, 0));
    send_item(make_req(ACT_LOS, 0, 0, 0, -32768));
    send_item(make_req(ACT_MARK, 32767, 32767, -32768, -32768));
    send_item(make_req(ACT_LOS, 0, 0, 0, 0));
    send_item(make_req(ACT_MARK, -32768, -32768, 32767, 32767));
    send_item(make_req(ACT_LOS, 0, 0, 0, 0));
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_GRID_WIDTH;
    cfg_data  = '0;
    cfg_width  = CFG_W'(256);
    cfg_height = CFG_W'(256);
    foreach (grid_occupied[i]) grid_occupied[i] = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_clean_grid();
    test_mark_clamp();
    test_size_change();
    test_back_pressure();
    test_random_phases();
    test_register_extremes();

    wait_results_drained();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tb_occupancy_grid_line_of_sight_top: done, clean");
    else
      $display("tb_occupancy_grid_line_of_sight_top: done, errors");
    $finish;
  end

endmodule
